// ===== rtl/rgbmf_pkg.sv =====
// Shared constants, types and helpers for the RGB median filter.
package rgbmf_pkg;

  localparam int PixW         = 24;
  localparam int ChW          = 8;
  localparam int CfgWidthW    = 12;
  localparam int RadW         = 2;
  localparam int DrW          = 2;
  localparam int RankW        = 6;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 12;
  localparam int DefMaxWidth  = 2048;
  localparam int DefMaxRadius = 2;

  localparam logic [CfgWidthW-1:0] WidthReset  = 12'd640;
  localparam logic [RadW-1:0]      RadiusReset = 2'd1;
  localparam logic [DrW-1:0]       DrainMax    = 2'd3;

  localparam logic [CfgIdxW-1:0] RegLineWidth    = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFilterRadius = 1'b1;

  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctl_t;

  function automatic logic [RankW-1:0] median_rank(input logic [RadW-1:0] r);
    logic [RankW-1:0] k;
    case (r)
      2'd0: k = 6'd0;
      2'd1: k = 6'd4;
      2'd2: k = 6'd12;
      2'd3: k = 6'd24;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/rgbmf_cell.sv =====
// One window column cell: holds a vertical pixel vector and on a shift takes its neighbor's or the fill vector.
module rgbmf_cell
  import rgbmf_pkg::*;
#(
  parameter int Side = 5
) (
  input  logic                      clk_i,
  input  cell_ctl_t                 ctl_i,
  input  logic [Side-1:0][PixW-1:0] fill_col_i,
  input  logic [Side-1:0][PixW-1:0] nbr_col_i,
  output logic [Side-1:0][PixW-1:0] col_o
);

  logic [Side-1:0][PixW-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      col_q <= ctl_i.fill ? fill_col_i : nbr_col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== rtl/rgbmf_lines.sv =====
// Line store memory holding all row ages of a column in one word, with write forwarding.
module rgbmf_lines
  import rgbmf_pkg::*;
#(
  parameter int Ages     = 4,
  parameter int MaxWidth = 2048,
  localparam int AddrW   = $clog2(MaxWidth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [Ages-1:0][PixW-1:0] wr_data_i,
  output logic [Ages-1:0][PixW-1:0] rd_data_o
);

  logic [Ages*PixW-1:0]      mem [MaxWidth];
  logic [Ages*PixW-1:0]      rdat_q;
  logic [Ages-1:0][PixW-1:0] fwd_data_q;
  logic                      fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdat_q     <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdat_q;

endmodule

// ===== rtl/rgbmf_rank.sv =====
// Rank selection for one channel: registered rank counts, then pick of the median.
module rgbmf_rank
  import rgbmf_pkg::*;
#(
  parameter int Ne = 25
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [Ne-1:0][ChW-1:0]  vals_i,
  input  logic [Ne-1:0]           mask_i,
  input  logic [RankW-1:0]        k_i,
  output logic [ChW-1:0]          med_o
);

  logic [Ne-1:0][RankW-1:0] lt_d, le_d, lt_q, le_q;
  logic [Ne-1:0][ChW-1:0]   vals_q;
  logic [Ne-1:0]            mask_q;
  logic [RankW-1:0]         k_q;

  always_comb begin
    for (int i = 0; i < Ne; i++) begin
      lt_d[i] = '0;
      le_d[i] = '0;
      for (int m = 0; m < Ne; m++) begin
        if (mask_i[m] && (vals_i[m] < vals_i[i])) begin
          lt_d[i] = lt_d[i] + RankW'(1);
        end
        if (mask_i[m] && (vals_i[m] <= vals_i[i])) begin
          le_d[i] = le_d[i] + RankW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lt_q   <= lt_d;
      le_q   <= le_d;
      vals_q <= vals_i;
      mask_q <= mask_i;
      k_q    <= k_i;
    end
  end

  always_comb begin
    med_o = '0;
    for (int i = 0; i < Ne; i++) begin
      if (mask_q[i] && (lt_q[i] <= k_q) && (le_q[i] > k_q)) begin
        med_o = med_o | vals_q[i];
      end
    end
  end

endmodule

// ===== rtl/median_filter_rgb.sv =====
// Top level of the streaming RGB median filter.
// Pixels enter in raster order at one pixel per clock while in_ready_o is high; a result passes
// the stage one registers, the window cells, the rank registers and the output register. Once R
// rows of the frame are stored, the last pixel of a row holds the window chain while each of the
// R trailing centres of the row takes one shift of the column cells, and stage one waits
// meanwhile. The line store is one memory with a single read and a single write port per cycle;
// its contents need no clearing after reset, so the block is ready at once.
module median_filter_rgb
  import rgbmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_RADIUS = DefMaxRadius
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic                frame_start_i,
  input  logic [ChW-1:0]      red_in_i,
  input  logic [ChW-1:0]      green_in_i,
  input  logic [ChW-1:0]      blue_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ChW-1:0]      red_median_o,
  output logic [ChW-1:0]      green_median_o,
  output logic [ChW-1:0]      blue_median_o,
  output logic                last_of_run_o
);

  localparam int Side = 2 * MAX_RADIUS + 1;
  localparam int Ages = 2 * MAX_RADIUS;
  localparam int Ne   = Side * Side;
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RfW  = $clog2(Ages + 1);
  localparam int CmpW = (ColW + 1 > CfgWidthW) ? ColW + 1 : CfgWidthW;

  // Configuration.
  logic [CfgWidthW-1:0] width_q;
  logic [RadW-1:0]      radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      radius_q <= RadiusReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegLineWidth) begin
        width_q <= cfg_data_i[CfgWidthW-1:0];
      end
      if (cfg_idx_i == RegFilterRadius) begin
        radius_q <= cfg_data_i[RadW-1:0];
      end
    end
  end

  // Input stage control.
  logic [ColW-1:0] col_q, col0;
  logic [RfW-1:0]  rf_q, rf0;
  logic [DrW-1:0]  dr_q, dr0;
  logic [RadW-1:0] r_eff;
  logic [CmpW-1:0] w_eff;
  logic            in_fire, ignore, enter, last0, rf_ge_r, emit0, has_ext;

  always_comb begin
    r_eff = (int'(radius_q) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : radius_q;
    if (width_q == '0) begin
      w_eff = CmpW'(1);
    end else if (CmpW'(width_q) > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = CmpW'(width_q);
    end
    col0    = frame_start_i ? '0 : col_q;
    rf0     = frame_start_i ? '0 : rf_q;
    dr0     = frame_start_i ? '0 : dr_q;
    last0   = (CmpW'(col0) + CmpW'(1)) >= w_eff;
    rf_ge_r = int'(rf0) >= int'(r_eff);
    ignore  = func_i && ((rf0 == '0) || (dr0 >= r_eff));
    emit0   = rf_ge_r && (CmpW'(col0) >= CmpW'(r_eff));
    has_ext = last0 && rf_ge_r && (r_eff != '0);
  end

  logic s1_v_q, s1_fire;

  assign in_ready_o = !s1_v_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign enter      = in_fire && !ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      rf_q  <= '0;
      dr_q  <= '0;
    end else if (in_fire) begin
      col_q <= col0;
      rf_q  <= rf0;
      dr_q  <= dr0;
      if (!ignore) begin
        if (last0) begin
          col_q <= '0;
          if (int'(rf0) < Ages) begin
            rf_q <= rf0 + RfW'(1);
          end
          if (func_i && (dr0 < DrainMax)) begin
            dr_q <= dr0 + DrW'(1);
          end
        end else begin
          col_q <= col0 + ColW'(1);
        end
      end
    end
  end

  // Stage one: line store read outstanding.
  logic [ColW-1:0] s1_col_q;
  logic [RfW-1:0]  s1_rf_q;
  logic [RadW-1:0] s1_r_q;
  logic [PixW-1:0] s1_pix_q;
  logic            s1_drain_q, s1_emit_q, s1_ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (enter) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enter) begin
      s1_col_q   <= col0;
      s1_rf_q    <= rf0;
      s1_r_q     <= r_eff;
      s1_pix_q   <= {red_in_i, green_in_i, blue_in_i};
      s1_drain_q <= func_i;
      s1_emit_q  <= emit0;
      s1_ext_q   <= has_ext;
    end
  end

  logic [Ages-1:0][PixW-1:0] rd_data, wr_data;
  logic [Side-1:0][PixW-1:0] vec;
  logic [PixW-1:0]           pix;

  rgbmf_lines #(
    .Ages    (Ages),
    .MaxWidth(MAX_WIDTH)
  ) u_lines (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (enter),
    .rd_addr_i(col0),
    .wr_en_i  (s1_fire),
    .wr_addr_i(s1_col_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  always_comb begin
    int e;
    pix = s1_drain_q ? rd_data[0] : s1_pix_q;
    for (int a = 0; a < Side; a++) begin
      e = (a < int'(s1_rf_q)) ? a : int'(s1_rf_q);
      if (e == 0) begin
        vec[a] = pix;
      end else begin
        vec[a] = rd_data[e-1];
      end
    end
    wr_data[0] = pix;
    for (int a = 1; a < Ages; a++) begin
      wr_data[a] = rd_data[a-1];
    end
  end

  // Window chain stepping.
  logic [RadW-1:0]           ext_cnt_q, ext_k_q, ext_r_q;
  logic [ColW-1:0]           ext_col_q;
  logic [Side-1:0][PixW-1:0] ext_vec_q, step_vec;
  logic                      ext_busy, ext_fire, ext_emit, ext_last, w_adv, c_ready;
  logic                      w_v_q, w_last_q;
  logic [RadW-1:0]           w_r_q;
  cell_ctl_t                 cell_ctl;

  assign ext_busy = ext_cnt_q != '0;
  assign w_adv    = !w_v_q || c_ready;
  assign s1_fire  = s1_v_q && !ext_busy && w_adv;
  assign ext_fire = ext_busy && w_adv;
  assign ext_emit = (CmpW'(ext_col_q) + CmpW'(ext_k_q)) >= CmpW'(ext_r_q);
  assign ext_last = ext_k_q == ext_r_q;
  assign step_vec = ext_busy ? ext_vec_q : vec;

  assign cell_ctl.shift = s1_fire || ext_fire;
  assign cell_ctl.fill  = s1_fire && (s1_col_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_cnt_q <= '0;
      w_v_q     <= 1'b0;
    end else begin
      if (s1_fire && s1_ext_q) begin
        ext_cnt_q <= s1_r_q;
      end else if (ext_fire) begin
        ext_cnt_q <= ext_cnt_q - RadW'(1);
      end
      if (w_adv) begin
        w_v_q <= (s1_fire && s1_emit_q) || (ext_fire && ext_emit);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_ext_q) begin
      ext_k_q   <= RadW'(1);
      ext_r_q   <= s1_r_q;
      ext_col_q <= s1_col_q;
      ext_vec_q <= vec;
    end else if (ext_fire) begin
      ext_k_q <= ext_k_q + RadW'(1);
    end
    if (s1_fire) begin
      w_last_q <= !s1_ext_q;
      w_r_q    <= s1_r_q;
    end else if (ext_fire) begin
      w_last_q <= ext_last;
      w_r_q    <= ext_r_q;
    end
  end

  logic [Side-1:0][Side-1:0][PixW-1:0] win;

  for (genvar s = 0; s < Side; s++) begin : g_cell
    logic [Side-1:0][PixW-1:0] nbr;
    if (s == Side - 1) begin : g_last
      assign nbr = step_vec;
    end else begin : g_mid
      assign nbr = win[s+1];
    end
    rgbmf_cell #(
      .Side(Side)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (cell_ctl),
      .fill_col_i(step_vec),
      .nbr_col_i (nbr),
      .col_o     (win[s])
    );
  end

  // Rank stage.
  logic [Ne-1:0][ChW-1:0] red_vals, green_vals, blue_vals;
  logic [Ne-1:0]          mask;
  logic [ChW-1:0]         red_med, green_med, blue_med;
  logic                   c_v_q, c_last_q, o_ready, c_en;

  always_comb begin
    for (int s = 0; s < Side; s++) begin
      for (int j = 0; j < Side; j++) begin
        red_vals[s*Side+j]   = win[s][j][23:16];
        green_vals[s*Side+j] = win[s][j][15:8];
        blue_vals[s*Side+j]  = win[s][j][7:0];
        mask[s*Side+j]       = (s >= Side - 1 - 2 * int'(w_r_q)) && (j <= 2 * int'(w_r_q));
      end
    end
  end

  assign o_ready = !out_valid_o || out_ready_i;
  assign c_ready = !c_v_q || o_ready;
  assign c_en    = c_ready && w_v_q;

  rgbmf_rank #(.Ne(Ne)) u_rank_red (
    .clk_i(clk_i), .en_i(c_en), .vals_i(red_vals), .mask_i(mask),
    .k_i(median_rank(w_r_q)), .med_o(red_med)
  );

  rgbmf_rank #(.Ne(Ne)) u_rank_green (
    .clk_i(clk_i), .en_i(c_en), .vals_i(green_vals), .mask_i(mask),
    .k_i(median_rank(w_r_q)), .med_o(green_med)
  );

  rgbmf_rank #(.Ne(Ne)) u_rank_blue (
    .clk_i(clk_i), .en_i(c_en), .vals_i(blue_vals), .mask_i(mask),
    .k_i(median_rank(w_r_q)), .med_o(blue_med)
  );

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_v_q <= w_v_q;
      end
      if (o_ready) begin
        out_valid_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_last_q <= w_last_q;
    end
    if (o_ready && c_v_q) begin
      red_median_o   <= red_med;
      green_median_o <= green_med;
      blue_median_o  <= blue_med;
      last_of_run_o  <= c_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/median_filter_rgb_chk.sv =====
// Port-level checker for the RGB median filter, bound to the top level.
module median_filter_rgb_chk
  import rgbmf_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input logic [ChW-1:0] red_median_o,
  input logic [ChW-1:0] green_median_o,
  input logic [ChW-1:0] blue_median_o,
  input logic           last_of_run_o
);

  // A result beat that is not taken stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_median_o) &&
    $stable(green_median_o) && $stable(blue_median_o) && $stable(last_of_run_o))
    else $error("result beat dropped or changed while stalled");

  // With no input beat offered, a ready input side stays ready.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("input side lost ready while idle");

  // Leaving reset, the block is empty and ready.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o && !out_valid_o)
    else $error("block not empty after reset");

endmodule

bind median_filter_rgb median_filter_rgb_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .red_median_o  (red_median_o),
  .green_median_o(green_median_o),
  .blue_median_o (blue_median_o),
  .last_of_run_o (last_of_run_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the streaming RGB median filter.
`timescale 1ns / 100ps

class median_scoreboard;
  logic [23:0] rows [4][2048];
  logic [23:0] win [5][5];
  int unsigned col_pos, rows_done, drains_done;
  int unsigned width_cfg, radius_cfg;
  logic [24:0] pending [$];
  int unsigned errors, results_seen;

  function void clear_state();
    col_pos = 0;
    rows_done = 0;
    drains_done = 0;
    width_cfg = 640;
    radius_cfg = 1;
    for (int a = 0; a < 4; a++) begin
      for (int c = 0; c < 2048; c++) begin
        rows[a][c] = '0;
      end
    end
    for (int s = 0; s < 5; s++) begin
      for (int a = 0; a < 5; a++) begin
        win[s][a] = '0;
      end
    end
  endfunction

  function void set_reg(logic [0:0] idx, logic [11:0] value);
    if (idx == rgbmf_pkg::RegLineWidth) width_cfg = value;
    else radius_cfg = value[1:0];
  endfunction

  function logic [7:0] channel_median(int unsigned r, int unsigned sh);
    logic [7:0] v [$];
    int unsigned first;
    first = 4 - 2 * r;
    for (int c = 0; c <= 2 * r; c++) begin
      for (int a = 0; a <= 2 * r; a++) begin
        v.push_back(8'(win[first + c][a] >> sh));
      end
    end
    v.sort();
    return v[v.size() / 2];
  endfunction

  function void shift_in(logic [23:0] vec [5]);
    for (int s = 0; s < 4; s++) win[s] = win[s + 1];
    win[4] = vec;
  endfunction

  function void queue_median(int unsigned r);
    pending.push_back({channel_median(r, 16), channel_median(r, 8), channel_median(r, 0), 1'b0});
  endfunction

  function int note_input(logic drain, logic fs, logic [23:0] px);
    int unsigned r, w, col, n, e;
    logic [23:0] pix;
    logic [23:0] vec [5];
    logic last;
    r = radius_cfg > 2 ? 2 : radius_cfg;
    w = width_cfg == 0 ? 1 : (width_cfg > 2048 ? 2048 : width_cfg);
    if (fs) begin
      col_pos = 0;
      rows_done = 0;
      drains_done = 0;
    end
    col = col_pos > 2047 ? 2047 : col_pos;
    n = 0;
    if (drain) begin
      if (rows_done == 0 || drains_done >= r) return 0;
      pix = rows[0][col];
    end else begin
      pix = px;
    end
    for (int a = 0; a < 5; a++) begin
      e = a < rows_done ? a : rows_done;
      vec[a] = e == 0 ? pix : rows[e - 1][col];
    end
    for (int a = 3; a >= 1; a--) rows[a][col] = rows[a - 1][col];
    rows[0][col] = pix;
    if (col == 0) begin
      for (int s = 0; s < 5; s++) win[s] = vec;
    end else begin
      shift_in(vec);
    end
    last = col + 1 >= w;
    if (rows_done >= r) begin
      if (col >= r) begin
        queue_median(r);
        n++;
      end
      if (last) begin
        for (int k = 1; k <= r; k++) begin
          shift_in(vec);
          if (col + k >= r) begin
            queue_median(r);
            n++;
          end
        end
      end
    end
    if (n > 0) pending[$][0] = 1'b1;
    if (last) begin
      col_pos = 0;
      if (rows_done < 4) rows_done++;
      if (drain && drains_done < 3) drains_done++;
    end else begin
      col_pos = col + 1;
    end
    return n;
  endfunction

  function void check_result(logic [24:0] got);
    logic [24:0] exp_val;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat %h", $time, got);
      errors++;
      return;
    end
    exp_val = pending.pop_front();
    if (exp_val[24:17] !== got[24:17])
      $display("%0t: red expected %h actual %h", $time, exp_val[24:17], got[24:17]);
    if (exp_val[16:9] !== got[16:9])
      $display("%0t: green expected %h actual %h", $time, exp_val[16:9], got[16:9]);
    if (exp_val[8:1] !== got[8:1])
      $display("%0t: blue expected %h actual %h", $time, exp_val[8:1], got[8:1]);
    if (exp_val[0] !== got[0])
      $display("%0t: last_of_run expected %b actual %b", $time, exp_val[0], got[0]);
    if (exp_val !== got) errors++;
  endfunction
endclass

module testbench;
  import rgbmf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic frame_start = 1'b0;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red_med, green_med, blue_med;
  logic last_run;
  median_scoreboard board = new();
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned stall_mode = 0;

  always #4 clk = ~clk;

  median_filter_rgb DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .frame_start_i(frame_start),
    .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .red_median_o(red_med), .green_median_o(green_med), .blue_median_o(blue_med),
    .last_of_run_o(last_run)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("median_filter_rgb verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result({red_med, green_med, blue_med, last_run});
    if ((cycle_count % 200) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (cycle_count % 7) < 3;
    endcase
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    board.set_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic drain, logic fs, logic [23:0] px, logic allow_gap);
    int unsigned gap;
    gap = (allow_gap && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= drain;
    frame_start <= fs;
    {red_in, green_in, blue_in} <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(board.note_input(drain, fs, px));
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned r, int unsigned style);
    logic [23:0] px;
    int unsigned wp;
    wp = (w == 0) ? 1 : w;
    write_reg(RegLineWidth, CfgDataW'(w));
    write_reg(RegFilterRadius, CfgDataW'(r));
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < wp; x++) begin
        case (style)
          0: px = 24'h000000;
          1: px = 24'hFFFFFF;
          2: px = ((x + y) & 1) ? 24'hFFFFFF : 24'h000000;
          default: px = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255))};
        endcase
        send_pixel(1'b0, x == 0 && y == 0, px, style > 2);
      end
    end
    for (int d = 0; d < r + 1; d++) begin
      for (int x = 0; x < wp; x++) send_pixel(1'b1, 1'b0, 24'h0, style > 2);
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    board.clear_state();
    // Drain before any row is complete, then four tiny directed frames.
    send_pixel(1'b1, 1'b1, 24'h123456, 1'b0);
    run_frame(1, 2, 0, 1);
    run_frame(3, 2, 1, 2);
    run_frame(2, 2, 2, 0);
    run_frame(4, 3, 3, 1);
    while (pixels_sent < 280) begin
      run_frame($urandom_range(1, 9), $urandom_range(1, 6), $urandom_range(0, 3), 3);
    end
    run_frame(0, 3, 1, 3);
    $display("Sent %0d pixel beats, checked %0d result beats over widths 0 to 9",
             pixels_sent, board.results_seen);
    $display("and radii 0 to 3, with random gaps and output stalls.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("median_filter_rgb verification clean");
    end else begin
      $display("median_filter_rgb verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rgbmf_pkg.sv
rtl/rgbmf_cell.sv
rtl/rgbmf_lines.sv
rtl/rgbmf_rank.sv
rtl/median_filter_rgb.sv
rtl/median_filter_rgb_chk.sv
sim/testbench.sv
